[rtl/lr_pkg.sv]
// shared constants, types and helpers for the line rasterizer
`default_nettype none
package lr_pkg;

	// grid geometry
	localparam int GRID_SIZE = 32;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	localparam int DELTA_W   = COORD_W + 1;
	// error term holds values below four times the major delta
	localparam int ERR_W     = COORD_W + 2;

	// characters
	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] ENDPOINT_CHAR   = 8'd43;
	localparam logic [CHAR_W-1:0] FILL_CHAR_RESET = 8'd42;

	// configuration register map
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam logic REG_FILL_CHAR = 1'b0;

	// stream payload widths, rounded up to whole bytes
	localparam int IN_FIELDS_W  = 4 * COORD_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * COORD_W + CHAR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// result of one step of the error accumulator
	typedef struct packed {
		logic             carry;
		logic [ERR_W-1:0] err;
	} step_res_t;

	// saturate a coordinate onto the grid
	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
		logic [COORD_W:0] wide;
		wide = {1'b0, c};
		if (wide > (COORD_W + 1)'(GRID_SIZE - 1)) begin
			clamp_coord = COORD_W'(GRID_SIZE - 1);
		end else begin
			clamp_coord = c;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/lr_step_unit.sv]
// shared error accumulator: one add, compare and subtract per major step
`default_nettype none
module lr_step_unit (
	input  wire logic [lr_pkg::ERR_W-1:0]   err,
	input  wire logic [lr_pkg::COORD_W-1:0] adm,
	input  wire logic [lr_pkg::COORD_W-1:0] dmaj,
	output lr_pkg::step_res_t               res
);

	logic [lr_pkg::ERR_W-1:0] sum;
	logic [lr_pkg::ERR_W-1:0] twice_maj;

	// add twice the minor delta, fold back by twice the major delta
	always_comb begin
		sum       = err + {1'b0, adm, 1'b0};
		twice_maj = {1'b0, dmaj, 1'b0};
		if (sum >= twice_maj) begin
			res.carry = 1'b1;
			res.err   = sum - twice_maj;
		end else begin
			res.carry = 1'b0;
			res.err   = sum;
		end
	end

endmodule
`default_nettype wire

[rtl/line_rasterizer.sv]
// line rasterizer top level: sequencer, configuration port and output register
//
// One line command enters on the s_ beat channel (two endpoints, 5 bits per coordinate).
// The block steps the major axis from the lower to the higher endpoint and
// sends one m_ beat per cell, carrying fill_char, then two beats that mark
// the origin and the end point with '+'; the last of these carries m_tlast.
// A command of major length d gives d + 3 result beats.
// Flow: a command is accepted, passes through a setup state, then one
// result beat leaves per cycle while m_tready stays high. The pace is set
// by the single error accumulator, which takes one major step per cycle
// while the output register can load.
// s_tready is high only while the sequencer is idle; the final mark may
// still wait in the output register while the next command is taken.
// When the receiver holds m_tready low, the output register holds its beat
// and the sequencer waits.
// Reset clears the sequencer and the output valid flag and sets fill_char
// to 42. fill_char is written over the APB port at any address with paddr[2] low (0 to 3).
`default_nettype none
module line_rasterizer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// slave beat: x_start[4:0], y_start[9:5], x_end[14:10], y_end[19:15]
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [lr_pkg::IN_DATA_W-1:0]       s_tdata,
	// master beat: cell_x[4:0], cell_y[9:5], cell_char[17:10]
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [lr_pkg::OUT_DATA_W-1:0]           m_tdata,
	output logic                                    m_tlast,
	// configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [lr_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [lr_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [lr_pkg::CFG_DATA_W-1:0]           prdata,
	output logic                                    pready
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_MARK0 = 5'b01000,
		ST_MARK1 = 5'b10000
	} state_t;

	state_t state_q;

	logic [lr_pkg::CHAR_W-1:0]  fill_q;

	// latched endpoints
	logic [lr_pkg::COORD_W-1:0] xs_q, ys_q, xe_q, ye_q;

	// stepping registers
	logic [lr_pkg::COORD_W-1:0] maj_q, maj_end_q, min_q, adm_q, dmaj_q;
	logic [lr_pkg::ERR_W-1:0]   err_q;
	logic                       neg_q, steep_q;

	// output register
	logic                       valid_q;
	logic [lr_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [lr_pkg::CHAR_W-1:0]  ch_q;
	logic                       last_q;

	logic                       load;
	logic                       cfg_wr;
	lr_pkg::step_res_t          step;

	// setup terms
	logic signed [lr_pkg::DELTA_W-1:0] dx, dy;
	logic [lr_pkg::DELTA_W-1:0]        adx_w, ady_w;
	logic [lr_pkg::COORD_W-1:0]        adx, ady;
	logic                              steep;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lr_pkg::REG_FILL_CHAR) ?
		{{(lr_pkg::CFG_DATA_W - lr_pkg::CHAR_W){1'b0}}, fill_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= lr_pkg::FILL_CHAR_RESET;
		end else if (cfg_wr && paddr[2] == lr_pkg::REG_FILL_CHAR) begin
			fill_q <= pwdata[lr_pkg::CHAR_W-1:0];
		end
	end

	// handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign load     = !valid_q || m_tready;

	// deltas and major axis choice
	always_comb begin
		dx    = $signed({1'b0, xe_q}) - $signed({1'b0, xs_q});
		dy    = $signed({1'b0, ye_q}) - $signed({1'b0, ys_q});
		adx_w = dx[lr_pkg::DELTA_W-1] ? lr_pkg::DELTA_W'(-dx) : lr_pkg::DELTA_W'(dx);
		ady_w = dy[lr_pkg::DELTA_W-1] ? lr_pkg::DELTA_W'(-dy) : lr_pkg::DELTA_W'(dy);
		adx   = adx_w[lr_pkg::COORD_W-1:0];
		ady   = ady_w[lr_pkg::COORD_W-1:0];
		steep = ady > adx;
	end

	lr_step_unit u_step (
		.err  (err_q),
		.adm  (adm_q),
		.dmaj (dmaj_q),
		.res  (step)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_RUN;
				ST_RUN: begin
					if (load && maj_q == maj_end_q) begin
						state_q <= ST_MARK0;
					end
				end
				ST_MARK0: begin
					if (load) begin
						state_q <= ST_MARK1;
					end
				end
				ST_MARK1: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// endpoint capture and stepping datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			xs_q <= lr_pkg::clamp_coord(s_tdata[lr_pkg::COORD_W-1:0]);
			ys_q <= lr_pkg::clamp_coord(s_tdata[2*lr_pkg::COORD_W-1:lr_pkg::COORD_W]);
			xe_q <= lr_pkg::clamp_coord(s_tdata[3*lr_pkg::COORD_W-1:2*lr_pkg::COORD_W]);
			ye_q <= lr_pkg::clamp_coord(s_tdata[4*lr_pkg::COORD_W-1:3*lr_pkg::COORD_W]);
		end
		if (state_q == ST_SETUP) begin
			steep_q <= steep;
			if (steep) begin
				dmaj_q <= ady;
				adm_q  <= adx;
				err_q  <= {2'b00, ady};
				if (ys_q <= ye_q) begin
					maj_q <= ys_q; maj_end_q <= ye_q; min_q <= xs_q;
					neg_q <= dx[lr_pkg::DELTA_W-1];
				end else begin
					maj_q <= ye_q; maj_end_q <= ys_q; min_q <= xe_q;
					neg_q <= !dx[lr_pkg::DELTA_W-1] && (dx != '0);
				end
			end else begin
				dmaj_q <= adx;
				adm_q  <= ady;
				err_q  <= {2'b00, adx};
				if (xs_q <= xe_q) begin
					maj_q <= xs_q; maj_end_q <= xe_q; min_q <= ys_q;
					neg_q <= dy[lr_pkg::DELTA_W-1];
				end else begin
					maj_q <= xe_q; maj_end_q <= xs_q; min_q <= ye_q;
					neg_q <= !dy[lr_pkg::DELTA_W-1] && (dy != '0);
				end
			end
		end else if (state_q == ST_RUN && load && maj_q != maj_end_q) begin
			maj_q <= maj_q + 1'b1;
			err_q <= step.err;
			if (step.carry) begin
				min_q <= neg_q ? min_q - 1'b1 : min_q + 1'b1;
			end
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= (state_q == ST_RUN) || (state_q == ST_MARK0) ||
				(state_q == ST_MARK1);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			case (state_q)
				ST_RUN: begin
					cx_q   <= steep_q ? min_q : maj_q;
					cy_q   <= steep_q ? maj_q : min_q;
					ch_q   <= fill_q;
					last_q <= 1'b0;
				end
				ST_MARK0: begin
					cx_q   <= xs_q;
					cy_q   <= ys_q;
					ch_q   <= lr_pkg::ENDPOINT_CHAR;
					last_q <= 1'b0;
				end
				ST_MARK1: begin
					cx_q   <= xe_q;
					cy_q   <= ye_q;
					ch_q   <= lr_pkg::ENDPOINT_CHAR;
					last_q <= 1'b1;
				end
				default: begin
					last_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(lr_pkg::OUT_DATA_W - lr_pkg::OUT_FIELDS_W){1'b0}}, ch_q, cy_q, cx_q};

	// a taken command always goes through setup next
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_SETUP)
		else $error("accepted command did not enter setup");

	// the closing beat is always an endpoint mark
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> ch_q == lr_pkg::ENDPOINT_CHAR)
		else $error("last beat is not an endpoint mark");

	// error term stays below twice the major delta while stepping
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && dmaj_q != '0 |-> err_q < {1'b0, dmaj_q, 1'b0})
		else $error("error accumulator out of range");

endmodule
`default_nettype wire
